[hdl/rain_sensor_debounce_reporter_defines.svh]
// Assertion macros shared by the rain sensor debounce reporter modules.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef RAIN_SENSOR_DEBOUNCE_REPORTER_DEFINES_SVH
`define RAIN_SENSOR_DEBOUNCE_REPORTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RSDR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rsdr: same-cycle check failed");
`define RSDR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rsdr: next-cycle check failed");
`else
`define RSDR_ASSERT_IMP(lbl, ante, cons)
`define RSDR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[hdl/rsdr_pkg.sv]
package rsdr_pkg;

    localparam int ADC_BITS = 12;
    localparam int FIELD_W  = 12;

    localparam int unsigned SAMPLE_MASK = (32'd1 << ADC_BITS) - 32'd1;
    localparam int unsigned BAND_LO_CNT = (32'd625 << ADC_BITS) >> 12;
    localparam int unsigned BAND_HI_CNT = (32'd3125 << ADC_BITS) >> 12;

    localparam logic [11:0] RST_THR_DRY   = 12'd1250;
    localparam logic [11:0] RST_THR_MID   = 12'd2500;
    localparam logic [11:0] RST_THR_WET   = 12'd3750;
    localparam logic [31:0] RST_DEBOUNCE  = 32'd4000;
    localparam logic [31:0] RST_RESEND    = 32'd1800000;
    localparam logic [15:0] RST_STEP      = 16'd1000;

    typedef enum logic [2:0] {
        CFG_RAIN_THR_DRY = 3'd0,
        CFG_RAIN_THR_MID = 3'd1,
        CFG_RAIN_THR_WET = 3'd2,
        CFG_DEBOUNCE_MS  = 3'd3,
        CFG_RESEND_LIMIT = 3'd4,
        CFG_CHECK_STEP   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        WX_UNKNOWN = 2'd0,
        WX_SUNNY   = 2'd1,
        WX_RAINY   = 2'd2
    } t_weather;

    typedef enum logic [1:0] {
        BAND_LO  = 2'd0,
        BAND_MID = 2'd1,
        BAND_HI  = 2'd2
    } t_band;

    typedef struct packed {
        logic [11:0] rain_thr_dry;
        logic [11:0] rain_thr_mid;
        logic [11:0] rain_thr_wet;
        logic [31:0] debounce_ms;
        logic [31:0] resend_limit;
        logic [15:0] check_step;
    } t_cfg;

    typedef struct packed {
        logic                 radio_busy;
        logic [FIELD_W-1:0]   rain_pot_ad;
        logic [FIELD_W-1:0]   fan_pot_ad;
        logic [FIELD_W-1:0]   rain_ad;
        logic [31:0]          now_ms;
    } t_item;

    typedef struct packed {
        logic                 checked;
        logic                 send_report;
        logic [FIELD_W-1:0]   report_value;
        t_weather             weather_now;
        t_band                fan_level;
        t_band                rain_band;
    } t_result;

    function automatic logic [FIELD_W-1:0] mask_sample(input logic [FIELD_W-1:0] s);
        return s & FIELD_W'(SAMPLE_MASK);
    endfunction

    function automatic t_band band_of(input logic [FIELD_W-1:0] s);
        logic [31:0] v;
        v = 32'(mask_sample(s));
        if (v < BAND_LO_CNT) begin
            return BAND_LO;
        end else if (v < BAND_HI_CNT) begin
            return BAND_MID;
        end
        return BAND_HI;
    endfunction

endpackage

[hdl/rsdr_cfg_regs.sv]
module rsdr_cfg_regs
    import rsdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_RAIN_THR_DRY: n_cfg.rain_thr_dry = i_cfg_data[11:0];
                CFG_RAIN_THR_MID: n_cfg.rain_thr_mid = i_cfg_data[11:0];
                CFG_RAIN_THR_WET: n_cfg.rain_thr_wet = i_cfg_data[11:0];
                CFG_DEBOUNCE_MS:  n_cfg.debounce_ms  = i_cfg_data;
                CFG_RESEND_LIMIT: n_cfg.resend_limit = i_cfg_data;
                CFG_CHECK_STEP:   n_cfg.check_step   = i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rain_thr_dry <= RST_THR_DRY;
            r_cfg.rain_thr_mid <= RST_THR_MID;
            r_cfg.rain_thr_wet <= RST_THR_WET;
            r_cfg.debounce_ms  <= RST_DEBOUNCE;
            r_cfg.resend_limit <= RST_RESEND;
            r_cfg.check_step   <= RST_STEP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/rsdr_core.sv]
`include "rain_sensor_debounce_reporter_defines.svh"

module rsdr_core
    import rsdr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_weather    r_weather;
    t_weather    n_weather;
    logic [31:0] r_mark;
    logic [31:0] n_mark;
    logic [31:0] r_accum;
    logic [31:0] n_accum;
    logic        r_reported;
    logic        n_reported;
    t_band       r_rain_sel;
    t_band       n_rain_sel;
    t_band       r_fan_sel;
    t_band       n_fan_sel;

    logic [FIELD_W-1:0] s_rain;
    logic [11:0]        s_thr;
    logic               s_rainy;
    logic [31:0]        s_elapsed;
    logic               s_due;
    logic [32:0]        s_sum;
    logic [31:0]        s_sat;
    logic               s_send;
    t_result            s_result;

    assign s_rain    = mask_sample(i_item.rain_ad);
    assign s_elapsed = i_item.now_ms - r_mark;
    assign s_due     = (s_elapsed >= i_cfg.debounce_ms) && !r_reported;
    assign s_sum     = {1'b0, r_accum} + {17'b0, i_cfg.check_step};
    assign s_sat     = s_sum[32] ? 32'hFFFF_FFFF : s_sum[31:0];

    always_comb begin
        n_weather  = r_weather;
        n_mark     = r_mark;
        n_accum    = r_accum;
        n_reported = r_reported;
        n_rain_sel = r_rain_sel;
        n_fan_sel  = r_fan_sel;
        s_send     = 1'b0;
        s_thr      = i_cfg.rain_thr_wet;
        s_rainy    = 1'b0;
        if (!i_item.radio_busy) begin
            n_rain_sel = band_of(i_item.rain_pot_ad);
            n_fan_sel  = band_of(i_item.fan_pot_ad);
            case (n_rain_sel)
                BAND_LO:  s_thr = i_cfg.rain_thr_dry;
                BAND_MID: s_thr = i_cfg.rain_thr_mid;
                default:  s_thr = i_cfg.rain_thr_wet;
            endcase
            s_rainy = 32'(s_rain) >= 32'(s_thr);
            if (r_weather == WX_UNKNOWN) begin
                n_mark    = i_item.now_ms;
                n_weather = s_rainy ? WX_RAINY : WX_SUNNY;
            end else if (s_rainy) begin
                if (r_weather != WX_RAINY) begin
                    n_mark     = i_item.now_ms;
                    n_weather  = WX_RAINY;
                    n_reported = 1'b0;
                end else if (s_due) begin
                    n_reported = 1'b1;
                    n_accum    = 32'd0;
                    s_send     = 1'b1;
                end else if (s_sat > i_cfg.resend_limit) begin
                    n_accum = 32'd0;
                    s_send  = 1'b1;
                end else begin
                    n_accum = s_sat;
                end
            end else begin
                if (r_weather != WX_SUNNY) begin
                    n_mark     = i_item.now_ms;
                    n_weather  = WX_SUNNY;
                    n_reported = 1'b0;
                end else if (s_due) begin
                    n_reported = 1'b1;
                    n_accum    = 32'd0;
                    s_send     = 1'b1;
                end
            end
        end
    end

    always_comb begin
        s_result.checked      = !i_item.radio_busy;
        s_result.send_report  = s_send;
        s_result.report_value = s_send ? s_rain : '0;
        s_result.weather_now  = n_weather;
        s_result.fan_level    = n_fan_sel;
        s_result.rain_band    = n_rain_sel;
    end

    assign o_result = s_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weather  <= WX_UNKNOWN;
            r_mark     <= 32'd0;
            r_accum    <= 32'd0;
            r_reported <= 1'b0;
            r_rain_sel <= BAND_LO;
            r_fan_sel  <= BAND_LO;
        end else if (i_step) begin
            r_weather  <= n_weather;
            r_mark     <= n_mark;
            r_accum    <= n_accum;
            r_reported <= n_reported;
            r_rain_sel <= n_rain_sel;
            r_fan_sel  <= n_fan_sel;
        end
    end

    `RSDR_ASSERT_IMP(a_send_needs_class, i_step && s_send, n_weather != WX_UNKNOWN)
    `RSDR_ASSERT_NXT(a_busy_holds_state, i_step && i_item.radio_busy, $stable(r_weather) && $stable(r_mark) && $stable(r_accum))
    `RSDR_ASSERT_NXT(a_class_never_lost, r_weather != WX_UNKNOWN, r_weather != WX_UNKNOWN)

endmodule

[hdl/rain_sensor_debounce_reporter.sv]
// Channel   Direction  Handshake                  Word
// input     in         i_in_valid / o_in_ready    busy flag, pot samples, rain sample, time
// output    out        o_out_valid / i_out_ready  checked, report, class and bands
// config    in         i_cfg_we                   index i_cfg_idx, data i_cfg_data
//
// A word is registered on acceptance, and its result is registered when the core steps.
// Throughput is one word per cycle while the output is not stalled, set by the core,
// which updates its whole state on every step.
// Reset is synchronous and active low; it restores the register defaults and the state.
// When the output is stalled the input register holds one more word, then ready drops.
`include "rain_sensor_debounce_reporter_defines.svh"

module rain_sensor_debounce_reporter
    import rsdr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_radio_busy,
    input  logic [FIELD_W-1:0] i_rain_pot_ad,
    input  logic [FIELD_W-1:0] i_fan_pot_ad,
    input  logic [FIELD_W-1:0] i_rain_ad,
    input  logic [31:0]        i_now_ms,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_checked,
    output logic               o_send_report,
    output logic [FIELD_W-1:0] o_report_value,
    output logic [1:0]         o_weather_now,
    output logic [1:0]         o_fan_level,
    output logic [1:0]         o_rain_band,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    logic    step;
    t_cfg    cfg;
    t_result core_result;

    rsdr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rsdr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (cfg),
        .o_result (core_result)
    );

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item.radio_busy  <= i_radio_busy;
            r_in_item.rain_pot_ad <= i_rain_pot_ad;
            r_in_item.fan_pot_ad  <= i_fan_pot_ad;
            r_in_item.rain_ad     <= i_rain_ad;
            r_in_item.now_ms      <= i_now_ms;
        end
        if (step) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_checked      = r_out.checked;
    assign o_send_report  = r_out.send_report;
    assign o_report_value = r_out.report_value;
    assign o_weather_now  = r_out.weather_now;
    assign o_fan_level    = r_out.fan_level;
    assign o_rain_band    = r_out.rain_band;

    `RSDR_ASSERT_IMP(a_stall_only_when_full, !o_in_ready, r_in_valid && r_out_valid && !i_out_ready)
    `RSDR_ASSERT_NXT(a_step_fills_output, step, r_out_valid)
    `RSDR_ASSERT_NXT(a_pending_word_kept, r_in_valid && !step, r_in_valid)

endmodule

[tb/rain_sensor_debounce_reporter_tb.sv]
`timescale 1ns / 1ps

module rain_sensor_debounce_reporter_tb;
    import rsdr_pkg::*;

    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;
    localparam int STALL_LIMIT = 1000;
    localparam int SOAK_WORDS  = 100;

    class weather_scoreboard;
        t_cfg        regs;
        t_weather    wx;
        logic [31:0] mark_ms;
        logic [31:0] accum;
        bit          reported;
        t_band       rain_sel_q;
        t_band       fan_sel_q;
        t_result     expected_results[$];
        int          n_words;
        int          n_busy;
        int          n_reports;
        int          n_results;
        int          n_errors;

        function new();
            regs = '{RST_THR_DRY, RST_THR_MID, RST_THR_WET, RST_DEBOUNCE, RST_RESEND,
                     RST_STEP};
            wx = WX_UNKNOWN;
            mark_ms = '0;
            accum = '0;
            reported = 1'b0;
            rain_sel_q = BAND_LO;
            fan_sel_q = BAND_LO;
        endfunction

        function void apply_config(logic [2:0] idx, logic [31:0] data);
            case (idx)
                CFG_RAIN_THR_DRY: regs.rain_thr_dry = data[11:0];
                CFG_RAIN_THR_MID: regs.rain_thr_mid = data[11:0];
                CFG_RAIN_THR_WET: regs.rain_thr_wet = data[11:0];
                CFG_DEBOUNCE_MS:  regs.debounce_ms  = data;
                CFG_RESEND_LIMIT: regs.resend_limit = data;
                CFG_CHECK_STEP:   regs.check_step   = data[15:0];
                default: ;
            endcase
        endfunction

        function t_band band_for(logic [11:0] s);
            if (32'(s) < BAND_LO_CNT) return BAND_LO;
            if (32'(s) < BAND_HI_CNT) return BAND_MID;
            return BAND_HI;
        endfunction

        function logic [11:0] threshold_for(t_band b);
            case (b)
                BAND_LO:  return regs.rain_thr_dry;
                BAND_MID: return regs.rain_thr_mid;
                default:  return regs.rain_thr_wet;
            endcase
        endfunction

        function void note_word(t_item w);
            t_result     r;
            logic [11:0] thr;
            bit          rainy;
            bit          send;
            logic [32:0] sum;
            send = 1'b0;
            n_words++;
            if (w.radio_busy) begin
                n_busy++;
            end else begin
                rain_sel_q = band_for(w.rain_pot_ad);
                fan_sel_q = band_for(w.fan_pot_ad);
                thr = threshold_for(rain_sel_q);
                rainy = (w.rain_ad >= thr);
                if (wx == WX_UNKNOWN) begin
                    mark_ms = w.now_ms;
                    wx = rainy ? WX_RAINY : WX_SUNNY;
                end else if ((rainy && wx != WX_RAINY) || (!rainy && wx != WX_SUNNY)) begin
                    mark_ms = w.now_ms;
                    wx = rainy ? WX_RAINY : WX_SUNNY;
                    reported = 1'b0;
                end else if ((w.now_ms - mark_ms) >= regs.debounce_ms && !reported) begin
                    reported = 1'b1;
                    accum = '0;
                    send = 1'b1;
                end else if (rainy) begin
                    sum = {1'b0, accum} + {17'd0, regs.check_step};
                    accum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (accum > regs.resend_limit) begin
                        accum = '0;
                        send = 1'b1;
                    end
                end
            end
            r.checked = !w.radio_busy;
            r.send_report = send;
            r.report_value = send ? w.rain_ad : '0;
            r.weather_now = wx;
            r.fan_level = fan_sel_q;
            r.rain_band = rain_sel_q;
            if (send) n_reports++;
            expected_results.push_back(r);
        endfunction

        task report(string msg);
            n_errors++;
            if (n_errors <= 25) $display("ERROR at %0t: %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got_v, logic [31:0] want_v);
            if (got_v !== want_v) begin
                report($sformatf("result word %0d, %s: got %0h, expected %0h",
                                 n_results, name, got_v, want_v));
            end
        endtask

        task check_word(t_result got);
            t_result want;
            n_results++;
            if (expected_results.size() == 0) begin
                report($sformatf("result word %0d arrived with nothing expected", n_results));
                return;
            end
            want = expected_results.pop_front();
            compare_field("checked", 32'(got.checked), 32'(want.checked));
            compare_field("send_report", 32'(got.send_report), 32'(want.send_report));
            compare_field("report_value", 32'(got.report_value), 32'(want.report_value));
            compare_field("weather_now", 32'(got.weather_now), 32'(want.weather_now));
            compare_field("fan_level", 32'(got.fan_level), 32'(want.fan_level));
            compare_field("rain_band", 32'(got.rain_band), 32'(want.rain_band));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_radio_busy = 1'b0;
    logic [11:0] i_rain_pot_ad = '0;
    logic [11:0] i_fan_pot_ad = '0;
    logic [11:0] i_rain_ad = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_checked;
    logic        o_send_report;
    logic [11:0] o_report_value;
    logic [1:0]  o_weather_now;
    logic [1:0]  o_fan_level;
    logic [1:0]  o_rain_band;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    weather_scoreboard sb;
    bit                no_idle = 1'b0;
    logic [31:0]       sim_ms = 32'h0001_0000;
    int                n_settings = 1;
    int                stuck_cycles = 0;

    rain_sensor_debounce_reporter uut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles.", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic push_word(input t_item w);
        int gap;
        gap = no_idle ? 0 : $urandom_range(10, 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_radio_busy <= w.radio_busy;
        i_rain_pot_ad <= w.rain_pot_ad;
        i_fan_pot_ad <= w.fan_pot_ad;
        i_rain_ad <= w.rain_ad;
        i_now_ms <= w.now_ms;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_word(w);
    endtask

    task automatic drain_results();
        int      stall;
        t_result got;
        forever begin
            stall = no_idle ? 0 : $urandom_range(10, 0);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            got.checked = o_checked;
            got.send_report = o_send_report;
            got.report_value = o_report_value;
            got.weather_now = t_weather'(o_weather_now);
            got.fan_level = t_band'(o_fan_level);
            got.rain_band = t_band'(o_rain_band);
            sb.check_word(got);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.apply_config(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [11:0] dry, input logic [11:0] mid,
                                input logic [11:0] wet, input logic [31:0] deb,
                                input logic [31:0] lim, input logic [15:0] step);
        settle();
        write_reg(CFG_RAIN_THR_DRY, {20'($urandom), dry});
        write_reg(CFG_RAIN_THR_MID, {20'($urandom), mid});
        write_reg(CFG_RAIN_THR_WET, {20'($urandom), wet});
        write_reg(CFG_DEBOUNCE_MS, deb);
        write_reg(CFG_RESEND_LIMIT, lim);
        write_reg(CFG_CHECK_STEP, {16'($urandom), step});
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        n_settings++;
    endtask

    task automatic directed_word(input bit busy, input logic [11:0] rp, input logic [11:0] fp,
                                 input logic [11:0] ra, input logic [31:0] stamp);
        push_word('{busy, rp, fp, ra, stamp});
    endtask

    function automatic logic [11:0] pick_pot(input t_band b);
        bit at_edge;
        at_edge = ($urandom_range(3, 0) == 0);
        case (b)
            BAND_LO: begin
                if (at_edge) return $urandom_range(1, 0) ? 12'(BAND_LO_CNT - 1) : 12'd0;
                return 12'($urandom_range(BAND_LO_CNT - 1, 0));
            end
            BAND_MID: begin
                if (at_edge) return $urandom_range(1, 0) ? 12'(BAND_HI_CNT - 1) : 12'(BAND_LO_CNT);
                return 12'($urandom_range(BAND_HI_CNT - 1, BAND_LO_CNT));
            end
            default: begin
                if (at_edge) return $urandom_range(1, 0) ? 12'hFFF : 12'(BAND_HI_CNT);
                return 12'($urandom_range(4095, BAND_HI_CNT));
            end
        endcase
    endfunction

    function automatic logic [11:0] pick_rain(input bit want_rain, input logic [11:0] thr);
        if (want_rain || thr == 12'd0) begin
            if ($urandom_range(3, 0) == 0) return thr;
            return 12'($urandom_range(4095, thr));
        end
        if ($urandom_range(3, 0) == 0) return thr - 12'd1;
        return 12'($urandom_range(thr - 1, 0));
    endfunction

    function automatic logic [31:0] next_step();
        logic [31:0] d;
        d = sb.regs.debounce_ms;
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return $urandom_range(d >> 1, 0);
            4: return d - 32'd1;
            5: return d;
            6: return d + 32'd1;
            7, 8: return $urandom_range(20, 0);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_weather(input int n_words);
        int    done_words;
        int    len;
        bit    wet;
        t_item w;
        t_item x;
        done_words = 0;
        while (done_words < n_words) begin
            wet = 1'($urandom_range(1, 0));
            len = $urandom_range(12, 1);
            no_idle = ($urandom_range(4, 0) == 0);
            w.radio_busy = 1'b0;
            w.rain_pot_ad = pick_pot(t_band'($urandom_range(2, 0)));
            w.fan_pot_ad = pick_pot(t_band'($urandom_range(2, 0)));
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(19, 0) == 0) w.rain_pot_ad = pick_pot(t_band'($urandom_range(2, 0)));
                if ($urandom_range(9, 0) == 0) w.fan_pot_ad = pick_pot(t_band'($urandom_range(2, 0)));
                w.rain_ad = pick_rain(wet ^ ($urandom_range(9, 0) == 0),
                                      sb.threshold_for(sb.band_for(w.rain_pot_ad)));
                sim_ms += next_step();
                w.now_ms = sim_ms;
                x = w;
                case ($urandom_range(19, 0))
                    0, 1: x = {1'b1, 12'($urandom), 12'($urandom), 12'($urandom), $urandom};
                    2: x = {1'($urandom), 12'($urandom), 12'($urandom), 12'($urandom), $urandom};
                    default: ;
                endcase
                push_word(x);
                if (!x.radio_busy) done_words++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        t_item w;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_results();
        join_none

        directed_word(1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
        directed_word(1'b0, 12'd0, 12'd0, 12'd1250, 32'hFFFF_FF00);
        directed_word(1'b0, 12'd624, 12'd0, 12'd1250, 32'h0000_0E9F);
        directed_word(1'b0, 12'd624, 12'd0, 12'hFFF, 32'h0000_0EA0);
        directed_word(1'b1, 12'd0, 12'd0, 12'd0, 32'h0000_0000);
        directed_word(1'b0, 12'd625, 12'd625, 12'd2499, 32'h0000_1000);
        directed_word(1'b0, 12'd3124, 12'd3124, 12'd2500, 32'h0000_1001);
        directed_word(1'b0, 12'd3125, 12'd3125, 12'd3749, 32'h0000_1002);
        directed_word(1'b0, 12'hFFF, 12'hFFF, 12'd3750, 32'h0000_2000);
        directed_word(1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 32'h0000_2FA0);
        directed_word(1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 32'h0000_3000);
        directed_word(1'b0, 12'd0, 12'd624, 12'd0, 32'h0000_3001);
        directed_word(1'b0, 12'd0, 12'd624, 12'd1249, 32'h0000_3FA1);
        directed_word(1'b0, 12'd0, 12'd624, 12'd0, 32'h0000_5000);
        run_weather(250);

        program_regs(12'd0, 12'hFFF, 12'd2048, 32'd0, 32'd0, 16'd0);
        run_weather(200);
        program_regs(12'hFFF, 12'd0, 12'hFFF, 32'hFFFF_FFFF, 32'd3000, 16'd1000);
        run_weather(200);
        program_regs(12'($urandom), 12'($urandom), 12'($urandom), 32'd50, 32'd0, 16'hFFFF);
        run_weather(200);
        repeat (3) begin
            program_regs(12'($urandom), 12'($urandom), 12'($urandom),
                         $urandom_range(20000, 0), $urandom_range(10000, 0),
                         16'($urandom_range(3000, 0)));
            run_weather(250);
        end

        program_regs(12'd0, 12'd0, 12'd0, 32'd0, 32'hFFFF_FFFF, 16'hFFFF);
        no_idle = 1'b1;
        for (int n = 0; n < SOAK_WORDS + 10; n++) begin
            if (n == SOAK_WORDS) begin
                settle();
                write_reg(CFG_RESEND_LIMIT, 32'hFFFF_FFFE);
            end
            w = {1'b0, 12'($urandom), 12'($urandom), 12'($urandom), sim_ms};
            sim_ms += 32'($urandom_range(100, 0));
            push_word(w);
        end
        no_idle = 1'b0;

        settle();
        repeat (10) @(posedge i_clk);
        $display("Covered %0d words (%0d with the radio busy), %0d expected reports, %0d settings,",
                 sb.n_words, sb.n_busy, sb.n_reports, n_settings);
        $display("including a gapless rainy run at the largest step; %0d mismatches seen.",
                 sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
